// ===== hdl/dsp_pkg.sv =====
// Shared types and constants for the DAG shortest-path block.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package dsp_pkg;

  // Fixed graph limits and field widths.
  localparam int unsigned MAX_NODES     = 16;
  localparam int unsigned MAX_EDGES_DEF = 64;
  localparam int unsigned NODE_W        = $clog2(MAX_NODES);
  localparam int unsigned CNT_W         = NODE_W + 1;
  localparam int unsigned COST_W        = 16;
  localparam int unsigned DIST_W        = 32;
  localparam int unsigned CNT_RESET     = MAX_NODES;

  // Request kinds on the input channel.
  typedef enum logic [0:0] {
    KIND_EDGE = 1'b0,
    KIND_RUN  = 1'b1
  } kind_e;

  // One stored edge.
  typedef struct packed {
    logic [NODE_W-1:0] tail;
    logic [NODE_W-1:0] head;
    logic [COST_W-1:0] weight;
  } edge_t;

  localparam int unsigned EDGE_W = $bits(edge_t);

  // Read address source of the distance memory.
  typedef enum logic [1:0] {
    BC_FIN  = 2'd0,
    BC_HEAD = 2'd1,
    BC_EMIT = 2'd2
  } bc_sel_e;

  // Controller states, one-hot.
  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_W_ROOT = 12'b0000_0000_0010,
    ST_W_ERD  = 12'b0000_0000_0100,
    ST_W_EEV  = 12'b0000_0000_1000,
    ST_R_INIT = 12'b0000_0001_0000,
    ST_R_NODE = 12'b0000_0010_0000,
    ST_R_BASE = 12'b0000_0100_0000,
    ST_R_ERD  = 12'b0000_1000_0000,
    ST_R_EEV  = 12'b0001_0000_0000,
    ST_R_CMP  = 12'b0010_0000_0000,
    ST_E_RD   = 12'b0100_0000_0000,
    ST_E_LD   = 12'b1000_0000_0000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_edge;
    logic    start_run;
    logic    root_skip;
    logic    root_take;
    logic    edge_next;
    logic    push;
    logic    pop;
    logic    src_init;
    logic    node_load;
    logic    node_done;
    logic    base_load;
    logic    cand_load;
    logic    relax_write;
    logic    emit_load;
    bc_sel_e bc_sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic edge_end;
    logic walk_match;
    logic relax_match;
    logic root_end;
    logic root_visited;
    logic stack_empty;
    logic k_zero;
    logic known_u;
    logic better;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/dsp_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module dsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/dsp_ctrl.sv =====
// Sequencer of the DAG shortest-path block: walk, relaxation and result phases.
// Depends on dsp_pkg; drives the datapath through dsp_pkg::cmd_t.
`default_nettype none

module dsp_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            kind_i,
  input  wire dsp_pkg::status_t status_i,
  output dsp_pkg::cmd_t        cmd_o,
  output logic                 in_stall_o
);

  dsp_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.bc_sel = dsp_pkg::BC_FIN;
    in_stall_o   = 1'b1;
    unique case (state_q)
      dsp_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (kind_i == dsp_pkg::KIND_RUN) begin
            cmd_o.start_run = 1'b1;
            state_d         = dsp_pkg::ST_W_ROOT;
          end else begin
            cmd_o.load_edge = 1'b1;
          end
        end
      end
      // Pick the next unvisited root in increasing order.
      dsp_pkg::ST_W_ROOT: begin
        if (status_i.root_end) begin
          state_d = dsp_pkg::ST_R_INIT;
        end else if (status_i.root_visited) begin
          cmd_o.root_skip = 1'b1;
        end else begin
          cmd_o.root_take = 1'b1;
          state_d         = dsp_pkg::ST_W_ERD;
        end
      end
      // Edge read in flight; finish the node when its edges are exhausted.
      dsp_pkg::ST_W_ERD: begin
        if (status_i.edge_end) begin
          cmd_o.pop = 1'b1;
          state_d   = status_i.stack_empty ? dsp_pkg::ST_W_ROOT : dsp_pkg::ST_W_ERD;
        end else begin
          state_d = dsp_pkg::ST_W_EEV;
        end
      end
      dsp_pkg::ST_W_EEV: begin
        if (status_i.walk_match) begin
          cmd_o.push = 1'b1;
        end else begin
          cmd_o.edge_next = 1'b1;
        end
        state_d = dsp_pkg::ST_W_ERD;
      end
      // Source distance is zero.
      dsp_pkg::ST_R_INIT: begin
        cmd_o.src_init = 1'b1;
        state_d        = dsp_pkg::ST_R_NODE;
      end
      // Take nodes from the finish list backwards.
      dsp_pkg::ST_R_NODE: begin
        cmd_o.bc_sel = dsp_pkg::BC_FIN;
        if (status_i.k_zero) begin
          state_d = dsp_pkg::ST_E_RD;
        end else if (!status_i.known_u) begin
          cmd_o.node_done = 1'b1;
        end else begin
          cmd_o.node_load = 1'b1;
          state_d         = dsp_pkg::ST_R_BASE;
        end
      end
      dsp_pkg::ST_R_BASE: begin
        cmd_o.base_load = 1'b1;
        state_d         = dsp_pkg::ST_R_ERD;
      end
      dsp_pkg::ST_R_ERD: begin
        if (status_i.edge_end) begin
          cmd_o.node_done = 1'b1;
          state_d         = dsp_pkg::ST_R_NODE;
        end else begin
          state_d = dsp_pkg::ST_R_EEV;
        end
      end
      dsp_pkg::ST_R_EEV: begin
        cmd_o.bc_sel = dsp_pkg::BC_HEAD;
        if (status_i.relax_match) begin
          cmd_o.cand_load = 1'b1;
          state_d         = dsp_pkg::ST_R_CMP;
        end else begin
          cmd_o.edge_next = 1'b1;
          state_d         = dsp_pkg::ST_R_ERD;
        end
      end
      dsp_pkg::ST_R_CMP: begin
        cmd_o.relax_write = status_i.better;
        cmd_o.edge_next   = 1'b1;
        state_d           = dsp_pkg::ST_R_ERD;
      end
      // One result per node, ascending.
      dsp_pkg::ST_E_RD: begin
        cmd_o.bc_sel = dsp_pkg::BC_EMIT;
        state_d      = dsp_pkg::ST_E_LD;
      end
      dsp_pkg::ST_E_LD: begin
        cmd_o.bc_sel = dsp_pkg::BC_EMIT;
        if (status_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          state_d = status_i.emit_last ? dsp_pkg::ST_IDLE : dsp_pkg::ST_E_RD;
        end
      end
      default: begin
        state_d = dsp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/dsp_dp.sv =====
// Datapath of the DAG shortest-path block: edge store, walk stack, distances
// and the result register. Depends on dsp_pkg and dsp_ram.
`default_nettype none

module dsp_dp #(
  parameter int unsigned MAX_EDGES = dsp_pkg::MAX_EDGES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire dsp_pkg::cmd_t                  cmd_i,
  output dsp_pkg::status_t                    status_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [dsp_pkg::CNT_W-1:0]      cfg_wdata_i,
  input  wire logic [dsp_pkg::NODE_W-1:0]     from_node_i,
  input  wire logic [dsp_pkg::NODE_W-1:0]     to_node_i,
  input  wire logic signed [dsp_pkg::COST_W-1:0] edge_cost_i,
  input  wire logic [dsp_pkg::NODE_W-1:0]     start_node_i,
  input  wire logic                           out_stall_i,
  output logic                                out_valid_o,
  output logic [dsp_pkg::NODE_W-1:0]          node_index_o,
  output logic signed [dsp_pkg::DIST_W-1:0]   distance_o,
  output logic                                reachable_o,
  output logic                                last_o
);

  localparam int unsigned EAW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ECW   = $clog2(MAX_EDGES + 1);
  localparam int unsigned NN    = dsp_pkg::MAX_NODES;
  localparam int unsigned NW    = dsp_pkg::NODE_W;
  localparam int unsigned CW    = dsp_pkg::CNT_W;
  localparam int unsigned DW    = dsp_pkg::DIST_W;

  // Control registers.
  logic [ECW-1:0] edge_total_q;
  logic [CW-1:0]  node_count_q;
  logic [CW-1:0]  n_q;
  logic [NW-1:0]  src_q;
  logic [NN-1:0]  visited_q;
  logic [NN-1:0]  known_q;
  logic [CW-1:0]  root_q;
  logic [NW-1:0]  cur_u_q;
  logic [ECW-1:0] cur_e_q;
  logic [NW-1:0]  depth_q;
  logic [CW-1:0]  done_q;
  logic [CW-1:0]  k_q;
  logic           out_valid_q;

  // Payload registers.
  logic [NW-1:0]        stk_node_q [NN];
  logic [ECW-1:0]       stk_edge_q [NN];
  logic [NW-1:0]        fin_q [NN];
  logic signed [DW-1:0] base_q;
  logic signed [DW-1:0] cand_q;
  logic [NW-1:0]        v_q;
  logic [NW-1:0]        node_index_q;
  logic signed [DW-1:0] distance_q;
  logic                 reachable_q;
  logic                 last_q;

  // Memory ports.
  dsp_pkg::edge_t e_rd;
  dsp_pkg::edge_t e_wr;
  logic           e_we;
  logic [DW-1:0]  bc_rd;
  logic [NW-1:0]  bc_raddr;
  logic [NW-1:0]  bc_waddr;
  logic [DW-1:0]  bc_wdata;
  logic           bc_we;

  logic [CW-1:0]  n_clamp;
  logic [CW-1:0]  k_m1;
  logic [NW-1:0]  fin_u;
  logic           in_graph;
  logic           tail_hit;
  logic signed [DW-1:0] cand_sum;
  logic           out_free;

  // Node count in use: zero counts as one, large values clamp to the store size.
  always_comb begin
    if (node_count_q == '0) begin
      n_clamp = CW'(1);
    end else if (node_count_q > CW'(NN)) begin
      n_clamp = CW'(NN);
    end else begin
      n_clamp = node_count_q;
    end
  end

  assign k_m1  = k_q - CW'(1);
  assign fin_u = fin_q[k_m1[NW-1:0]];

  // Edge store.
  assign e_we        = cmd_i.load_edge && (edge_total_q < ECW'(MAX_EDGES));
  assign e_wr.tail   = from_node_i;
  assign e_wr.head   = to_node_i;
  assign e_wr.weight = edge_cost_i;

  dsp_ram #(
    .WIDTH (dsp_pkg::EDGE_W),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (edge_total_q[EAW-1:0]),
    .wdata_i (e_wr),
    .raddr_i (cur_e_q[EAW-1:0]),
    .rdata_o (e_rd)
  );

  // Distance memory address and write selection.
  always_comb begin
    case (cmd_i.bc_sel)
      dsp_pkg::BC_FIN:  bc_raddr = fin_u;
      dsp_pkg::BC_HEAD: bc_raddr = e_rd.head;
      dsp_pkg::BC_EMIT: bc_raddr = k_q[NW-1:0];
      default:          bc_raddr = '0;
    endcase
  end

  assign bc_we    = cmd_i.src_init || cmd_i.relax_write;
  assign bc_waddr = cmd_i.src_init ? src_q : v_q;
  assign bc_wdata = cmd_i.src_init ? '0 : cand_q;

  dsp_ram #(
    .WIDTH (DW),
    .DEPTH (NN)
  ) u_cost_ram (
    .clk_i   (clk_i),
    .we_i    (bc_we),
    .waddr_i (bc_waddr),
    .wdata_i (bc_wdata),
    .raddr_i (bc_raddr),
    .rdata_o (bc_rd)
  );

  // Edge qualification against the current node and the graph size.
  assign in_graph = ({1'b0, e_rd.tail} < n_q) && ({1'b0, e_rd.head} < n_q);
  assign tail_hit = (e_rd.tail == cur_u_q) && in_graph;
  assign cand_sum = base_q + DW'($signed(e_rd.weight));
  assign out_free = !out_valid_q || !out_stall_i;

  // Status towards the controller.
  always_comb begin
    status_o.edge_end     = (cur_e_q == edge_total_q);
    status_o.walk_match   = tail_hit && !visited_q[e_rd.head];
    status_o.relax_match  = tail_hit;
    status_o.root_end     = (root_q == n_q);
    status_o.root_visited = visited_q[root_q[NW-1:0]];
    status_o.stack_empty  = (depth_q == '0);
    status_o.k_zero       = (k_q == '0);
    status_o.known_u      = known_q[fin_u];
    status_o.better       = !known_q[v_q] || (cand_q < $signed(bc_rd));
    status_o.emit_last    = (k_q == n_q - CW'(1));
    status_o.out_free     = out_free;
  end

  // Control state of the walk, relaxation and result phases.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_total_q <= '0;
      node_count_q <= CW'(dsp_pkg::CNT_RESET);
      n_q          <= CW'(NN);
      src_q        <= '0;
      visited_q    <= '0;
      known_q      <= '0;
      root_q       <= '0;
      cur_u_q      <= '0;
      cur_e_q      <= '0;
      depth_q      <= '0;
      done_q       <= '0;
      k_q          <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      if (e_we) begin
        edge_total_q <= edge_total_q + ECW'(1);
      end
      if (cmd_i.start_run) begin
        n_q       <= n_clamp;
        src_q     <= start_node_i;
        visited_q <= '0;
        known_q   <= ({1'b0, start_node_i} < n_clamp) ? (NN'(1) << start_node_i) : '0;
        root_q    <= '0;
        done_q    <= '0;
        depth_q   <= '0;
        k_q       <= n_clamp;
      end
      if (cmd_i.root_skip) begin
        root_q <= root_q + CW'(1);
      end
      if (cmd_i.root_take) begin
        visited_q[root_q[NW-1:0]] <= 1'b1;
        cur_u_q <= root_q[NW-1:0];
        cur_e_q <= '0;
        root_q  <= root_q + CW'(1);
      end
      if (cmd_i.edge_next) begin
        cur_e_q <= cur_e_q + ECW'(1);
      end
      // Descend into an unvisited neighbor; the caller resumes after this edge.
      if (cmd_i.push) begin
        visited_q[e_rd.head] <= 1'b1;
        cur_u_q <= e_rd.head;
        cur_e_q <= '0;
        depth_q <= depth_q + NW'(1);
      end
      // Finish the node and return to its caller, if any.
      if (cmd_i.pop) begin
        done_q <= done_q + CW'(1);
        if (depth_q != '0) begin
          cur_u_q <= stk_node_q[depth_q - NW'(1)];
          cur_e_q <= stk_edge_q[depth_q - NW'(1)];
          depth_q <= depth_q - NW'(1);
        end
      end
      if (cmd_i.node_load) begin
        cur_u_q <= fin_u;
        cur_e_q <= '0;
      end
      if (cmd_i.node_done) begin
        k_q <= k_m1;
      end
      if (cmd_i.relax_write) begin
        known_q[v_q] <= 1'b1;
      end
      // Result register: loads when free, empties when taken.
      if (cmd_i.emit_load) begin
        out_valid_q <= 1'b1;
        k_q         <= k_q + CW'(1);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Stack, finish list, relaxation operands and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      stk_node_q[depth_q] <= cur_u_q;
      stk_edge_q[depth_q] <= cur_e_q + ECW'(1);
    end
    if (cmd_i.pop) begin
      fin_q[done_q[NW-1:0]] <= cur_u_q;
    end
    if (cmd_i.base_load) begin
      base_q <= $signed(bc_rd);
    end else if (cmd_i.relax_write && (v_q == cur_u_q)) begin
      // A self-loop that improves the current node changes its base too.
      base_q <= cand_q;
    end
    if (cmd_i.cand_load) begin
      v_q    <= e_rd.head;
      cand_q <= cand_sum;
    end
    if (cmd_i.emit_load) begin
      node_index_q <= k_q[NW-1:0];
      reachable_q  <= known_q[k_q[NW-1:0]];
      distance_q   <= known_q[k_q[NW-1:0]] ? $signed(bc_rd) : '0;
      last_q       <= status_o.emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign node_index_o = node_index_q;
  assign distance_o   = distance_q;
  assign reachable_o  = reachable_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

// ===== hdl/dag_shortest_paths.sv =====
// Top level of the DAG shortest-path block: controller plus datapath.
// Depends on dsp_pkg, dsp_ctrl, dsp_dp and dsp_ram.
`default_nettype none

// An edge request (kind 0) is appended to the edge store; requests beyond
// MAX_EDGES stored edges are dropped. A run request (kind 1) holds the
// input stalled while a depth-first walk orders the nodes, edges are
// relaxed in reverse finish order, and one result per node in use is
// produced in ascending node order, the final one marked by last_o. The
// edge store has a single registered read port, so each edge examined
// takes a read state and an evaluate state, and a relaxed edge a compare
// state as well; output stalls hold the result phase. The node_count register
// is sampled when a run is taken; write it only while the block is idle.

module dag_shortest_paths #(
  parameter int unsigned MAX_EDGES = dsp_pkg::MAX_EDGES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [dsp_pkg::CNT_W-1:0]         cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              kind_i,
  input  wire logic [dsp_pkg::NODE_W-1:0]        from_node_i,
  input  wire logic [dsp_pkg::NODE_W-1:0]        to_node_i,
  input  wire logic signed [dsp_pkg::COST_W-1:0] edge_cost_i,
  input  wire logic [dsp_pkg::NODE_W-1:0]        start_node_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [dsp_pkg::NODE_W-1:0]             node_index_o,
  output logic signed [dsp_pkg::DIST_W-1:0]      distance_o,
  output logic                                   reachable_o,
  output logic                                   last_o
);

  dsp_pkg::cmd_t    cmd;
  dsp_pkg::status_t status;

  // Sequencer.
  dsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // Storage and arithmetic.
  dsp_dp #(
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .from_node_i  (from_node_i),
    .to_node_i    (to_node_i),
    .edge_cost_i  (edge_cost_i),
    .start_node_i (start_node_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .node_index_o (node_index_o),
    .distance_o   (distance_o),
    .reachable_o  (reachable_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

// ===== hdl/dsp_checker.sv =====
// Port-level checks for the DAG shortest-path block, bound to its top level.
// Depends on dsp_pkg.
`default_nettype none

module dsp_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_stall_o,
  input wire logic                              kind_i,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic [dsp_pkg::NODE_W-1:0]        node_index_o,
  input wire logic signed [dsp_pkg::DIST_W-1:0] distance_o,
  input wire logic                              reachable_o,
  input wire logic                              last_o
);

  logic                      run_acc;
  logic                      out_acc;
  logic [1:0]                pend_q;
  logic [dsp_pkg::NODE_W-1:0] exp_idx_q;

  assign run_acc = in_valid_i && !in_stall_o && (kind_i == dsp_pkg::KIND_RUN);
  assign out_acc = out_valid_o && !out_stall_i;

  // Runs whose final result has not yet been taken, and the next expected index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      exp_idx_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, run_acc} - {1'b0, out_acc && last_o};
      if (out_acc) begin
        exp_idx_q <= last_o ? '0 : node_index_o + dsp_pkg::NODE_W'(1);
      end
    end
  end

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(node_index_o)
      && $stable(distance_o) && $stable(reachable_o) && $stable(last_o))
    else $error("result changed while stalled");

  // A run request blocks further requests while it is worked on.
  a_run_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_acc |=> in_stall_o)
    else $error("input not stalled after a run request");

  // Results of a run come in ascending node order starting at zero.
  a_index_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> node_index_o == exp_idx_q)
    else $error("result node index out of sequence");

  // Results appear only for a run that is still open.
  a_out_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result without an open run");

endmodule

bind dag_shortest_paths dsp_checker u_dsp_checker (.*);

`default_nettype wire

// ===== verif/tb_dag_shortest_paths.sv =====
// Self-checking testbench for dag_shortest_paths: edge loads and path runs
// go in over the request channel, and each per-node result is checked.
// Depends on dsp_pkg and the dag_shortest_paths RTL.
module tb_dag_shortest_paths;
  timeunit 1ns;
  timeprecision 1ps;

  import dsp_pkg::*;

  localparam int unsigned EDGE_SLOTS    = MAX_EDGES_DEF;
  localparam int unsigned STALL_LIMIT   = 40000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned DRAIN_CYCLES  = 50;
  localparam int unsigned PHASE_ITEMS   = 38;

  // One request on the input channel.
  typedef struct {
    kind_e                    kind;
    logic [NODE_W-1:0]        from_n;
    logic [NODE_W-1:0]        to_n;
    logic signed [COST_W-1:0] cost;
    logic [NODE_W-1:0]        start;
  } graph_req_t;

  // One per-node distance result.
  typedef struct {
    logic [NODE_W-1:0]        node;
    logic signed [DIST_W-1:0] distance;
    logic                     reach;
    logic                     last;
  } path_result_t;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     cfg_we_i     = 1'b0;
  logic [CNT_W-1:0]         cfg_wdata_i  = '0;
  logic                     in_valid_i   = 1'b0;
  logic                     in_stall_o;
  logic                     kind_i       = 1'b0;
  logic [NODE_W-1:0]        from_node_i  = '0;
  logic [NODE_W-1:0]        to_node_i    = '0;
  logic signed [COST_W-1:0] edge_cost_i  = '0;
  logic [NODE_W-1:0]        start_node_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i  = 1'b0;
  logic [NODE_W-1:0]        node_index_o;
  logic signed [DIST_W-1:0] distance_o;
  logic                     reachable_o;
  logic                     last_o;

  dag_shortest_paths #(
    .MAX_EDGES(EDGE_SLOTS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .from_node_i (from_node_i),
    .to_node_i   (to_node_i),
    .edge_cost_i (edge_cost_i),
    .start_node_i(start_node_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .node_index_o(node_index_o),
    .distance_o  (distance_o),
    .reachable_o (reachable_o),
    .last_o      (last_o)
  );

  // Requests waiting to be driven and results waiting to be seen.
  graph_req_t   pending_reqs[$];
  path_result_t expected_paths[$];

  // Predictor copy of the block state.
  logic [NODE_W-1:0]        edge_tail [EDGE_SLOTS];
  logic [NODE_W-1:0]        edge_head [EDGE_SLOTS];
  logic signed [COST_W-1:0] edge_weight [EDGE_SLOTS];
  int unsigned              stored_edges = 0;
  logic [CNT_W-1:0]         node_limit   = CNT_W'(CNT_RESET);

  // Stimulus-side bookkeeping.
  int unsigned gen_stored     = 0;
  int unsigned gen_nodes      = MAX_NODES;
  int unsigned send_idle_pct  = 20;
  int unsigned recv_stall_pct = 67;
  int unsigned fault_count    = 0;
  int unsigned quiet_cycles   = 0;
  bit          req_taken      = 1'b0;

  // Clock: 8 ns period.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Node count actually used for a register value.
  function automatic int unsigned nodes_in_use(input logic [CNT_W-1:0] value);
    if (value == 0) return 1;
    if (value > MAX_NODES) return MAX_NODES;
    return value;
  endfunction

  function automatic bit edge_inside(input int unsigned e, input int unsigned n);
    return edge_tail[e] < n && edge_head[e] < n;
  endfunction

  // Expected results of a run: depth-first finish order, relaxation in
  // reverse finish order, then one result per node in ascending order.
  function automatic void solve_from(input logic [NODE_W-1:0] src);
    int unsigned n, done, sp, u, v, e, k, root;
    bit          seen [MAX_NODES];
    bit          known [MAX_NODES];
    int unsigned stk_node [MAX_NODES];
    int unsigned stk_edge [MAX_NODES];
    int unsigned order [MAX_NODES];
    longint      best [MAX_NODES];
    bit          pushed;
    longint      d;
    path_result_t r;
    n = nodes_in_use(node_limit);
    done = 0;
    for (k = 0; k < MAX_NODES; k++) begin
      seen[k]  = 1'b0;
      known[k] = 1'b0;
      best[k]  = 0;
    end
    for (root = 0; root < n; root++) begin
      if (!seen[root]) begin
        seen[root]  = 1'b1;
        stk_node[0] = root;
        stk_edge[0] = 0;
        sp = 1;
        while (sp > 0) begin
          u = stk_node[sp-1];
          e = stk_edge[sp-1];
          pushed = 1'b0;
          while (e < stored_edges && !pushed) begin
            if (edge_tail[e] == u && edge_inside(e, n) && !seen[edge_head[e]] &&
                sp < MAX_NODES) begin
              stk_edge[sp-1] = e + 1;
              v = edge_head[e];
              seen[v] = 1'b1;
              stk_node[sp] = v;
              stk_edge[sp] = 0;
              sp++;
              pushed = 1'b1;
            end else begin
              e++;
            end
          end
          if (!pushed) begin
            sp--;
            if (done < MAX_NODES) begin
              order[done] = u;
              done++;
            end
          end
        end
      end
    end

    if (src < n) begin
      known[src] = 1'b1;
      best[src]  = 0;
    end

    // Relax out-edges of each reached node, last finished first.
    for (k = done; k > 0; k--) begin
      u = order[k-1];
      if (known[u]) begin
        for (e = 0; e < stored_edges; e++) begin
          if (edge_tail[e] == u && edge_inside(e, n)) begin
            v = edge_head[e];
            d = best[u] + edge_weight[e];
            if (d > 64'sd2147483647) d = 64'sd2147483647;
            if (d < -64'sd2147483648) d = -64'sd2147483648;
            if (!known[v] || d < best[v]) begin
              best[v]  = d;
              known[v] = 1'b1;
            end
          end
        end
      end
    end

    for (k = 0; k < n; k++) begin
      r.node     = k[NODE_W-1:0];
      r.distance = known[k] ? best[k][DIST_W-1:0] : '0;
      r.reach    = known[k];
      r.last     = (k + 1 == n);
      expected_paths = {expected_paths, r};
    end
  endfunction

  task automatic log_fault(input string why);
    fault_count++;
    if (fault_count <= 10)
      $display("%0t %s; got node %0d distance %0d reachable %0b last %0b", $realtime,
               why, node_index_o, distance_o, reachable_o, last_o);
  endtask

  // Request driver: a new request appears at the falling edge after the
  // previous one was taken; idle gaps are inserted at random.
  always @(negedge clk_i) begin
    graph_req_t req;
    if (!in_valid_i || req_taken) begin
      req_taken = 1'b0;
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req = pending_reqs.pop_front();
        in_valid_i   <= 1'b1;
        kind_i       <= req.kind;
        from_node_i  <= req.from_n;
        to_node_i    <= req.to_n;
        edge_cost_i  <= req.cost;
        start_node_i <= req.start;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver stalls at random.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Monitor: updates the predictor on each taken request, checks each taken
  // result against the oldest expectation, and runs the watchdog.
  always @(posedge clk_i) begin
    path_result_t want;
    bit           moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        req_taken = 1'b1;
        moved = 1'b1;
        if (kind_i == KIND_RUN) begin
          solve_from(start_node_i);
        end else if (stored_edges < EDGE_SLOTS) begin
          edge_tail[stored_edges]   = from_node_i;
          edge_head[stored_edges]   = to_node_i;
          edge_weight[stored_edges] = edge_cost_i;
          stored_edges++;
        end
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (expected_paths.size() == 0) begin
          log_fault("result with nothing expected");
        end else begin
          want = expected_paths.pop_front();
          if (node_index_o !== want.node || distance_o !== want.distance ||
              reachable_o !== want.reach || last_o !== want.last)
            log_fault($sformatf("mismatch: expected node %0d distance %0d reachable %0b last %0b",
                                want.node, want.distance, want.reach, want.last));
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_dag_shortest_paths: errors");
        $finish;
      end
    end
  end

  task automatic queue_edge(input int unsigned a, input int unsigned b, input logic [15:0] c);
    graph_req_t req;
    logic [31:0] raw;
    raw = $urandom;
    req.kind   = KIND_EDGE;
    req.from_n = a[NODE_W-1:0];
    req.to_n   = b[NODE_W-1:0];
    req.cost   = c;
    req.start  = raw[NODE_W-1:0];
    pending_reqs = {pending_reqs, req};
    if (gen_stored < EDGE_SLOTS) gen_stored++;
  endtask

  task automatic queue_run(input int unsigned src);
    graph_req_t req;
    logic [31:0] raw;
    raw = $urandom;
    req.kind   = KIND_RUN;
    req.from_n = raw[NODE_W-1:0];
    req.to_n   = raw[2*NODE_W-1:NODE_W];
    req.cost   = raw[31:16];
    req.start  = src[NODE_W-1:0];
    pending_reqs = {pending_reqs, req};
  endtask

  // Waits until every request is taken and every result has arrived, then
  // lets the block settle.
  task automatic drain(input int unsigned settle);
    while (pending_reqs.size() != 0 || in_valid_i || expected_paths.size() != 0)
      @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Writes node_count while the block is idle.
  task automatic set_node_count(input int unsigned value);
    drain(SETTLE_CYCLES);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[CNT_W-1:0];
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    node_limit  = value[CNT_W-1:0];
    gen_nodes   = nodes_in_use(node_limit);
  endtask

  // Random phase: mostly forward edges and runs from a node in the graph,
  // with back edges, self loops, outside sources and dropped edges as noise.
  task automatic random_phase(input int unsigned target);
    int unsigned counted, a, b, hi;
    logic [31:0] raw;
    counted = 0;
    while (counted < target) begin
      raw = $urandom;
      if (gen_stored < EDGE_SLOTS && $urandom_range(0, 99) < 45) begin
        if ($urandom_range(0, 99) < 85) begin
          a  = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 6) : $urandom_range(0, 14);
          hi = (a + 3 > 15) ? 15 : a + 3;
          b  = ($urandom_range(0, 1) == 1) ? $urandom_range(a + 1, hi)
                                          : $urandom_range(a + 1, 15);
        end else begin
          a = $urandom_range(0, 15);
          b = $urandom_range(0, 15);
        end
        if ($urandom_range(0, 1) == 1) raw[15:0] = 16'($urandom_range(0, 40)) - 16'd20;
        queue_edge(a, b, raw[15:0]);
        counted++;
      end else if (gen_stored >= EDGE_SLOTS && $urandom_range(0, 99) < 5) begin
        // The store is full, so this edge is dropped.
        queue_edge(32'(raw[3:0]), 32'(raw[7:4]), raw[31:16]);
      end else begin
        if ($urandom_range(0, 99) < 85) queue_run($urandom_range(0, gen_nodes - 1));
        else queue_run($urandom_range(0, 15));
        counted++;
      end
    end
  endtask

  // Main sequence.
  initial begin
    int unsigned phase_counts [9];
    int unsigned p;
    phase_counts = '{16, 0, 5, 31, 1, 9, 2, 16, 13};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty store, extreme costs, parallel edges, a cycle,
    // a self loop and the highest node.
    queue_run(0);
    queue_edge(0, 1, 16'h7FFF);
    queue_edge(1, 2, 16'h7FFF);
    queue_edge(0, 2, 16'h8000);
    queue_edge(0, 1, 16'hFFF9);
    queue_edge(2, 15, 16'hFFFF);
    queue_edge(14, 15, 16'h0000);
    queue_edge(15, 3, 16'h0005);
    queue_edge(3, 0, 16'h0064);
    queue_edge(4, 4, 16'h0000);
    queue_run(0);
    queue_run(15);
    queue_run(14);
    queue_run(3);
    queue_run(4);

    // Small graphs: sources outside the graph and edges leaving it.
    set_node_count(3);
    queue_run(15);
    queue_run(2);
    queue_run(0);
    set_node_count(0);
    queue_run(0);
    queue_run(1);

    for (p = 0; p < 9; p++) begin
      set_node_count(phase_counts[p]);
      if (p < 3) begin
        send_idle_pct  = 20;
        recv_stall_pct = 67;
      end else if (p < 6) begin
        send_idle_pct  = 67;
        recv_stall_pct = 20;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      random_phase(PHASE_ITEMS);
    end

    drain(DRAIN_CYCLES);
    if (expected_paths.size() != 0) begin
      fault_count += expected_paths.size();
      $display("%0d expected results never arrived", expected_paths.size());
    end
    if (fault_count == 0) begin
      $display("tb_dag_shortest_paths: clean");
    end else begin
      $display("tb_dag_shortest_paths: errors");
    end
    $finish;
  end

endmodule

// ===== dag_shortest_paths.f =====
hdl/dsp_pkg.sv
hdl/dsp_ram.sv
hdl/dsp_ctrl.sv
hdl/dsp_dp.sv
hdl/dag_shortest_paths.sv
hdl/dsp_checker.sv
verif/tb_dag_shortest_paths.sv
